// ===== hw/rtl/cbm_pkg.sv =====
// package: constants, types and command/status structs for the cyclic bond marker
package cbm_pkg;

    localparam int unsigned MaxAtoms = 64;
    localparam int unsigned MaxBonds = 128;

    localparam logic [1:0] MODE_LOAD      = 2'd0;
    localparam logic [1:0] MODE_READ_BOND = 2'd1;
    localparam logic [1:0] MODE_READ_ATOM = 2'd2;
    localparam logic [1:0] MODE_UNDEF     = 2'd3;

    localparam logic [1:0] STAT_LOADED = 2'd0;
    localparam logic [1:0] STAT_DONE   = 2'd1;
    localparam logic [1:0] STAT_READ   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_BOND_RD,
        S_BOND_START,
        S_POP,
        S_POP_WAIT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_MARK,
        S_NEXT_BOND,
        S_RESP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic read;
        logic clr_start;
        logic clr_step;
        logic bond_rd;
        logic bond_start;
        logic pop;
        logic scan_first;
        logic scan_rd;
        logic scan_chk;
        logic mark;
        logic next_bond;
        logic resp;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic stack_empty;
        logic scan_last;
        logic found;
        logic bond_last;
        logic last_flag;
    } t_status;

endpackage

// ===== hw/rtl/cbm_if.sv =====
// valid/ready channel interface carrying one word of payload
interface cbm_if #(
    parameter int unsigned W = 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/cbm_ctrl.sv =====
// controller state machine sequencing load, read and the ring search
module cbm_ctrl
    import cbm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic [1:0] i_mode,
    input  logic    i_out_ready,
    input  t_status i_stat,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    logic w_acc;
    assign w_acc = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_mode == MODE_LOAD && i_stat.last_flag) n_state = S_CLEAR;
                    else if (i_mode != MODE_UNDEF)               n_state = S_RESP;
                end
            end
            S_CLEAR:      if (i_stat.clr_last) n_state = S_BOND_RD;
            S_BOND_RD:    n_state = S_BOND_START;
            S_BOND_START: n_state = S_POP;
            S_POP:        n_state = i_stat.stack_empty ? S_NEXT_BOND : S_POP_WAIT;
            S_POP_WAIT:   n_state = S_SCAN_RD;
            S_SCAN_RD:    n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (i_stat.found)          n_state = S_MARK;
                else if (i_stat.scan_last) n_state = S_POP;
                else                       n_state = S_SCAN_RD;
            end
            S_MARK:       n_state = S_NEXT_BOND;
            S_NEXT_BOND:  n_state = i_stat.bond_last ? S_RESP : S_BOND_RD;
            S_RESP:       if (i_out_ready) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.load   = w_acc && (i_mode == MODE_LOAD);
                o_cmd.read   = w_acc;
                o_cmd.clr_start = w_acc && (i_mode == MODE_LOAD) && i_stat.last_flag;
            end
            S_CLEAR:      o_cmd.clr_step   = 1'b1;
            S_BOND_RD:    o_cmd.bond_rd    = 1'b1;
            S_BOND_START: o_cmd.bond_start = 1'b1;
            S_POP:        o_cmd.pop        = 1'b1;
            S_POP_WAIT:   o_cmd.scan_first = 1'b1;
            S_SCAN_RD:    o_cmd.scan_rd    = 1'b1;
            S_SCAN_CHK:   o_cmd.scan_chk   = 1'b1;
            S_MARK:       o_cmd.mark       = 1'b1;
            S_NEXT_BOND:  o_cmd.next_bond  = 1'b1;
            S_RESP: begin
                o_out_valid = 1'b1;
                o_cmd.resp  = i_out_ready;
            end
            default: ;
        endcase
    end
endmodule

// ===== hw/rtl/cbm_dpath.sv =====
// datapath: bond store, search stack, marks and ring flags
module cbm_dpath
    import cbm_pkg::*;
#(
    parameter int unsigned MAX_ATOMS = MaxAtoms,
    parameter int unsigned MAX_BONDS = MaxBonds
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic [1:0] i_mode,
    input  logic [6:0] i_item_index,
    input  logic [5:0] i_first_atom,
    input  logic [5:0] i_second_atom,
    input  logic       i_last_bond,
    output t_status    o_stat,
    output logic [1:0] o_status,
    output logic [6:0] o_reported_index,
    output logic       o_cyclic_flag
);
    localparam int unsigned AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int unsigned BW = (MAX_BONDS > 1) ? $clog2(MAX_BONDS) : 1;
    localparam int unsigned CLRN = (MAX_ATOMS > MAX_BONDS) ? MAX_ATOMS : MAX_BONDS;
    localparam int unsigned CW = (CLRN > 1) ? $clog2(CLRN) : 1;

    // bond memory, one write port, one registered read port
    logic [2*AW-1:0] r_bond_mem [MAX_BONDS];
    logic [2*AW-1:0] r_rd;
    logic [BW-1:0]   w_rd_addr;

    logic [BW:0]   r_total;
    logic [BW-1:0] r_bond, r_scan;
    logic [AW-1:0] r_a1, r_a2, r_cur;
    logic [MAX_ATOMS-1:0] r_visited, r_atom_ring;
    logic [MAX_BONDS-1:0] r_used, r_bond_ring;
    logic [AW-1:0] r_stack [MAX_ATOMS];
    logic [AW:0]   r_top;
    logic [CW-1:0] r_clr;
    logic [1:0]    r_status;
    logic [6:0]    r_index;
    logic          r_flag;

    logic [AW-1:0] w_fa, w_sa, w_e1, w_e2, w_other;
    logic [BW-1:0] w_slot;
    logic          w_hit;

    assign w_fa   = AW'(i_first_atom % MAX_ATOMS);
    assign w_sa   = AW'(i_second_atom % MAX_ATOMS);
    assign w_slot = BW'(i_item_index % MAX_BONDS);
    assign w_e1   = r_rd[2*AW-1:AW];
    assign w_e2   = r_rd[AW-1:0];
    assign w_rd_addr = i_cmd.bond_rd ? r_bond : r_scan;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_bond_mem[w_slot] <= {w_fa, w_sa};
        r_rd <= r_bond_mem[w_rd_addr];
    end

    always_comb begin
        w_hit   = 1'b0;
        w_other = w_e2;
        if (!r_used[r_scan]) begin
            if (w_e1 == r_cur)      begin w_hit = 1'b1; w_other = w_e2; end
            else if (w_e2 == r_cur) begin w_hit = 1'b1; w_other = w_e1; end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_visited   <= '0;
            r_used      <= '0;
            r_top       <= '0;
            r_bond_ring <= '0;
            r_atom_ring <= '0;
            r_clr       <= '0;
            r_bond      <= '0;
            r_scan      <= '0;
        end else begin
            if (i_cmd.load) r_total <= (BW+1)'(w_slot) + 1'b1;
            if (i_cmd.clr_start) begin
                r_clr  <= '0;
                r_bond <= '0;
            end
            // one bond flag slot and one atom flag slot cleared per cycle
            if (i_cmd.clr_step) begin
                if (32'(r_clr) < MAX_BONDS) r_bond_ring[r_clr[BW-1:0]] <= 1'b0;
                if (32'(r_clr) < MAX_ATOMS) r_atom_ring[r_clr[AW-1:0]] <= 1'b0;
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.bond_start) begin
                r_a1 <= w_e1;
                r_a2 <= w_e2;
                r_visited <= MAX_ATOMS'(1) << w_e2;
                r_used <= MAX_BONDS'(1) << r_bond;
                r_stack[0] <= w_e2;
                r_top <= (AW+1)'(1);
            end
            if (i_cmd.pop && r_top != '0) begin
                r_cur <= r_stack[r_top[AW-1:0] - 1'b1];
                r_top <= r_top - 1'b1;
            end
            if (i_cmd.scan_first) r_scan <= '0;
            if (i_cmd.scan_chk) begin
                if (w_hit && w_other != r_a1 && !r_visited[w_other]) begin
                    r_visited[w_other] <= 1'b1;
                    r_used[r_scan] <= 1'b1;
                    if (32'(r_top) < MAX_ATOMS) begin
                        r_stack[r_top[AW-1:0]] <= w_other;
                        r_top <= r_top + 1'b1;
                    end
                end
                r_scan <= r_scan + 1'b1;
            end
            if (i_cmd.mark) begin
                r_bond_ring[r_bond] <= 1'b1;
                r_atom_ring <= r_atom_ring | (MAX_ATOMS'(1) << r_a1)
                                           | (MAX_ATOMS'(1) << r_a2);
            end
            if (i_cmd.next_bond) r_bond <= r_bond + 1'b1;
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_index <= i_item_index;
            r_flag  <= 1'b0;
            case (i_mode)
                MODE_LOAD:      r_status <= i_last_bond ? STAT_DONE : STAT_LOADED;
                MODE_READ_BOND: begin
                    r_status <= STAT_READ;
                    r_flag   <= r_bond_ring[w_slot];
                end
                MODE_READ_ATOM: begin
                    r_status <= STAT_READ;
                    r_flag   <= r_atom_ring[AW'(i_item_index % MAX_ATOMS)];
                end
                default: r_status <= STAT_LOADED;
            endcase
        end
    end

    assign o_status         = r_status;
    assign o_reported_index = r_index;
    assign o_cyclic_flag    = r_flag;

    assign o_stat.clr_last    = (32'(r_clr) == CLRN - 1);
    assign o_stat.stack_empty = (r_top == '0);
    assign o_stat.scan_last   = ((BW+1)'(r_scan) + 1'b1 >= r_total);
    assign o_stat.found       = w_hit && (w_other == r_a1);
    assign o_stat.bond_last   = ((BW+1)'(r_bond) + 1'b1 >= r_total);
    assign o_stat.last_flag   = i_last_bond;
endmodule

// ===== hw/rtl/cyclic_bond_marker.sv =====
// top level: cyclic bond marker, controller plus datapath
// Bonds are loaded one word at a time into slots; a load word with last_bond set
// starts the ring search and its response (status done) comes only once every
// bond in slots 0..n-1 has been searched. Any other load or read word is answered
// in the cycle after acceptance. The search is one depth-first walk per bond over
// the bond memory's one read port: each popped atom scans the bonds in turn,
// reading and then checking each, until a ring closes or all n are scanned. A
// flag clearing pass over max(MAX_ATOMS, MAX_BONDS) slots comes first.
// One word is handled at a time; mode 3 words are taken and give no response.
module cyclic_bond_marker
    import cbm_pkg::*;
#(
    parameter int unsigned MAX_ATOMS = MaxAtoms,
    parameter int unsigned MAX_BONDS = MaxBonds
)(
    input  logic  i_clk,
    input  logic  i_rst_n,
    cbm_if.sink   i_in,
    cbm_if.source o_out
);
    t_cmd    w_cmd;
    t_status w_stat;

    // input word layout: mode, item_index, first_atom, second_atom, last_bond
    logic [1:0] w_mode;
    assign w_mode = i_in.data[21:20];

    cbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_mode      (w_mode),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd)
    );

    // output word layout: status, reported_index, cyclic_flag
    cbm_dpath #(
        .MAX_ATOMS (MAX_ATOMS),
        .MAX_BONDS (MAX_BONDS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_mode           (w_mode),
        .i_item_index     (i_in.data[19:13]),
        .i_first_atom     (i_in.data[12:7]),
        .i_second_atom    (i_in.data[6:1]),
        .i_last_bond      (i_in.data[0]),
        .o_stat           (w_stat),
        .o_status         (o_out.data[9:8]),
        .o_reported_index (o_out.data[7:1]),
        .o_cyclic_flag    (o_out.data[0])
    );

    // no new word taken while a response waits
    a_no_accept_on_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready) else $error("input taken while response pending");

    // a response held stalled keeps its payload
    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.data))
        else $error("response changed while stalled");

    // a plain read answers in the cycle after acceptance
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && (w_mode == MODE_READ_BOND || w_mode == MODE_READ_ATOM)
        |=> o_out.valid) else $error("read response late");
endmodule

// ===== tb/tb_top.sv =====
// testbench: ring marking of loaded bond graphs checked against a behavioral ring search
module tb_top;
    import cbm_pkg::*;

    localparam int unsigned IN_W    = 22;
    localparam int unsigned OUT_W   = 10;
    localparam int unsigned LIMIT   = 3000000;
    localparam int unsigned HOLD_AT = 40;

    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] index;
        logic [5:0] atom_a;
        logic [5:0] atom_b;
        logic       last;
    } t_word;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] index;
        logic       flag;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cbm_if #(.W(IN_W))  in_ch ();
    cbm_if #(.W(OUT_W)) out_ch ();

    cyclic_bond_marker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // graph copy kept by the predictor
    logic [5:0] ends_a [MaxBonds];
    logic [5:0] ends_b [MaxBonds];
    int         n_bonds;
    bit         ring_bond [MaxBonds];
    bit         ring_atom [MaxAtoms];

    t_word   words_to_send [$];
    t_answer answers_due [$];
    int      total_words, sent, results, errors, rings_seen, graphs_done;
    int      cycles;
    bit      took;
    bit      quiet;

    // depth-first walk from the far end of bond b looking for its near end
    function automatic bit closes_ring(int b);
        bit         seen [MaxAtoms];
        bit         spent [MaxBonds];
        logic [5:0] pend [MaxAtoms];
        int         top;
        logic [5:0] cur, far_end;
        for (int i = 0; i < MaxAtoms; i++) seen[i] = 0;
        for (int i = 0; i < MaxBonds; i++) spent[i] = 0;
        seen[ends_b[b]] = 1;
        spent[b] = 1;
        pend[0] = ends_b[b];
        top = 1;
        while (top > 0) begin
            top--;
            cur = pend[top];
            for (int j = 0; j < n_bonds; j++) begin
                if (spent[j]) continue;
                if (ends_a[j] == cur) far_end = ends_b[j];
                else if (ends_b[j] == cur) far_end = ends_a[j];
                else continue;
                if (far_end == ends_a[b]) return 1;
                if (!seen[far_end]) begin
                    seen[far_end] = 1;
                    spent[j] = 1;
                    if (top < MaxAtoms) begin
                        pend[top] = far_end;
                        top++;
                    end
                end
            end
        end
        return 0;
    endfunction

    function automatic bit apply_word(t_word w, output t_answer ans);
        ans = '{status: STAT_LOADED, index: w.index, flag: 1'b0};
        case (w.mode)
            MODE_LOAD: begin
                ends_a[w.index] = w.atom_a;
                ends_b[w.index] = w.atom_b;
                n_bonds = int'(w.index) + 1;
                if (w.last) begin
                    for (int i = 0; i < MaxBonds; i++) ring_bond[i] = 0;
                    for (int i = 0; i < MaxAtoms; i++) ring_atom[i] = 0;
                    for (int b = 0; b < n_bonds; b++)
                        if (closes_ring(b)) begin
                            ring_bond[b] = 1;
                            ring_atom[ends_a[b]] = 1;
                            ring_atom[ends_b[b]] = 1;
                        end
                    ans.status = STAT_DONE;
                end
                return 1;
            end
            MODE_READ_BOND: begin
                ans.status = STAT_READ;
                ans.flag = ring_bond[w.index];
                return 1;
            end
            MODE_READ_ATOM: begin
                ans.status = STAT_READ;
                ans.flag = ring_atom[w.index[5:0]];
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    function automatic t_word mk(logic [1:0] m, int idx, int a, int b, bit l);
        t_word w;
        w.mode = m;
        w.index = idx[6:0];
        w.atom_a = a[5:0];
        w.atom_b = b[5:0];
        w.last = l;
        return w;
    endfunction

    // append one word to the pending stimulus
    task automatic queue_word(t_word w);
        words_to_send = {words_to_send, w};
    endtask

    // loads slots 0..k-1 from a small pool of atoms, then queries; mode 3 noise mixed in
    task automatic add_graph(int k, int base, int pool, int n_reads);
        for (int s = 0; s < k; s++) begin
            queue_word(mk(MODE_LOAD, s, base + $urandom_range(0, pool - 1),
                          base + $urandom_range(0, pool - 1), s == k - 1));
            if ($urandom_range(0, 9) == 0)
                queue_word(mk(MODE_UNDEF, $urandom, $urandom, $urandom,
                              $urandom_range(0, 1)));
        end
        for (int r = 0; r < n_reads; r++)
            if ($urandom_range(0, 1)) begin
                queue_word(mk(MODE_READ_BOND, $urandom_range(0, k + 2),
                              $urandom, $urandom, $urandom_range(0, 1)));
            end else begin
                queue_word(mk(MODE_READ_ATOM,
                              (base + $urandom_range(0, pool)) % 64
                              + 64 * $urandom_range(0, 1),
                              $urandom, $urandom, $urandom_range(0, 1)));
            end
    endtask

    // stimulus
    initial begin
        // reads before any computation see cleared flags
        queue_word(mk(MODE_READ_BOND, 127, 63, 0, 1));
        queue_word(mk(MODE_READ_ATOM, 63, 0, 63, 0));
        queue_word(mk(MODE_UNDEF, 127, 63, 63, 1));
        // triangle 0-1-2 plus a self loop on 63 and a dangling bond
        queue_word(mk(MODE_LOAD, 0, 0, 1, 0));
        queue_word(mk(MODE_LOAD, 1, 1, 2, 0));
        queue_word(mk(MODE_LOAD, 2, 2, 0, 0));
        queue_word(mk(MODE_LOAD, 3, 63, 63, 0));
        queue_word(mk(MODE_LOAD, 4, 2, 62, 1));
        for (int i = 0; i < 6; i++) queue_word(mk(MODE_READ_BOND, i, 0, 0, 0));
        queue_word(mk(MODE_READ_ATOM, 127, 0, 0, 0));
        queue_word(mk(MODE_READ_ATOM, 62, 0, 0, 0));
        queue_word(mk(MODE_READ_ATOM, 64, 0, 0, 0));
        // loads without last leave flags as they were
        queue_word(mk(MODE_LOAD, 0, 5, 6, 0));
        queue_word(mk(MODE_READ_BOND, 0, 0, 0, 0));
        // wide graph over few atoms reaches the upper slots
        add_graph(72, 60, 4, 4);
        queue_word(mk(MODE_READ_BOND, 71, 0, 0, 0));
        queue_word(mk(MODE_READ_BOND, 100, 0, 0, 0));
        // random graphs, mostly small
        while (words_to_send.size() < 140)
            add_graph($urandom_range(1, 8), $urandom_range(0, 63), $urandom_range(2, 6),
                      $urandom_range(3, 8));
        total_words = words_to_send.size();
    end

    // driver: inputs move on the falling edge
    int in_gap;
    always @(negedge i_clk) begin
        logic  nv;
        t_word nd;
        nv = in_ch.valid;
        nd = in_ch.data;
        if (!i_rst_n) begin
            nv = 1'b0;
            nd = '0;
        end else if (!in_ch.valid || took) begin
            nv = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                in_gap = $urandom_range(0, 13);
            end else if (words_to_send.size() > 0) begin
                nv = 1'b1;
                nd = words_to_send.pop_front();
            end
        end
        in_ch.valid <= nv;
        in_ch.data  <= nd;
    end

    // receiver: random stalls plus one long hold-off so the block backs up
    int  out_gap, hold_left;
    bit  held;
    always @(negedge i_clk) begin
        logic nr;
        nr = 1'b1;
        if (!i_rst_n) begin
            nr = 1'b0;
        end else if (!held && results >= HOLD_AT) begin
            held = 1;
            hold_left = 400;
            nr = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            nr = 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            nr = 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            out_gap = $urandom_range(0, 13);
            nr = 1'b0;
        end
        out_ch.ready <= nr;
    end

    // monitor: predict on input accept, check on output accept
    always @(posedge i_clk) begin
        t_answer exp_ans, got;
        cycles++;
        took = in_ch.valid && in_ch.ready && i_rst_n;
        if (took) begin
            sent++;
            quiet = sent > (total_words * 85) / 100;
            if (apply_word(t_word'(in_ch.data), exp_ans)) answers_due = {answers_due, exp_ans};
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = t_answer'(out_ch.data);
            results++;
            if (answers_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %h", got);
            end else begin
                exp_ans = answers_due.pop_front();
                if (got.status == STAT_DONE) graphs_done++;
                if (got.status == STAT_READ && got.flag) rings_seen++;
                if (got !== exp_ans) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: status %0d/%0d index %0d/%0d flag %0d/%0d",
                                 exp_ans.status, got.status, exp_ans.index, got.index,
                                 exp_ans.flag, got.flag);
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (total_words > 0 && sent == total_words);
        wait (answers_due.size() == 0);
        repeat (50) @(posedge i_clk);
        if (answers_due.size() != 0) errors++;
        $display("%0d words in, %0d results, %0d graphs computed, %0d ring flags read set",
                 sent, results, graphs_done, rings_seen);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", errors);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
